[rtl/ldrs_pkg.sv]
// Shared constants and payload types for the decimal LSD radix sorter.
package ldrs_pkg;

  localparam int unsigned VALUE_BITS   = 31;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned RADIX_DEF    = 10;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  last_res;
    logic                  overflow;
  } out_item_t;

endpackage

[rtl/ldrs_div_unit.sv]
// Divide by the radix through reciprocal multiplication; start registers the dividend, then the quotient.
module ldrs_div_unit #(
  parameter int unsigned RADIX = ldrs_pkg::RADIX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ldrs_pkg::VALUE_BITS-1:0] dividend_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [ldrs_pkg::VALUE_BITS-1:0] quot_o,
  output logic [$clog2(RADIX)-1:0]        digit_o
);

  localparam int unsigned     VB    = ldrs_pkg::VALUE_BITS;
  localparam int unsigned     DIG_W = $clog2(RADIX);
  localparam int unsigned     SH    = VB + DIG_W;
  localparam int unsigned     PW    = 2 * VB + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(RADIX) - 64'd1) / 64'(RADIX);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VB-1:0]    num_q, num_d;
  logic [VB-1:0]    quot_q, quot_d;
  logic [PW-1:0]    prod;
  logic [DIG_W-1:0] back_lo;

  assign prod    = PW'(num_q) * PW'(RECIP);
  assign back_lo = quot_q[DIG_W-1:0] * DIG_W'(RADIX);

  always_comb begin
    busy_d = 1'b0;
    done_d = 1'b0;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      num_d  = dividend_i;
    end else if (busy_q) begin
      done_d = 1'b1;
      quot_d = VB'(prod >> SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign quot_o  = quot_q;
  assign digit_o = num_q[DIG_W-1:0] - back_lo;

endmodule

[rtl/lsd_decimal_radix_sort_top.sv]
// Top level of the LSD radix sorter: sequencer, value stores and output register.
// Load: one cycle per input item; the set ends with the item marked last.
// Sort: P passes, P = digit count of the largest value; each pass runs every item through
//   the shared divider (S_EXT_RD/GO/WAIT), then scans all items once per bucket (S_DST_RD/CHK).
// Output: each result is read, then sent when the slot is free; input stays stalled until the last result loads.
// Reset clears control state only; stores are not cleared (never read before written).
module lsd_decimal_radix_sort_top #(
  parameter int unsigned CAPACITY = ldrs_pkg::CAPACITY_DEF,
  parameter int unsigned RADIX    = ldrs_pkg::RADIX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ldrs_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ldrs_pkg::out_item_t out_data_o
);

  localparam int unsigned VB    = ldrs_pkg::VALUE_BITS;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DIG_W = $clog2(RADIX);

  typedef enum logic [7:0] {
    S_LOAD     = 8'b0000_0001,
    S_EXT_RD   = 8'b0000_0010,
    S_EXT_GO   = 8'b0000_0100,
    S_EXT_WAIT = 8'b0000_1000,
    S_DST_RD   = 8'b0001_0000,
    S_DST_CHK  = 8'b0010_0000,
    S_OUT_RD   = 8'b0100_0000,
    S_OUT_SEND = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [DIG_W-1:0] bkt_q, bkt_d;
  logic             ovf_q, ovf_d;
  logic             more_q, more_d;
  logic             out_valid_q, out_valid_d;
  ldrs_pkg::out_item_t out_data_q, out_data_d;

  logic [VB-1:0]    a_val_mem [CAPACITY];
  logic [VB-1:0]    a_quo_mem [CAPACITY];
  logic [DIG_W-1:0] a_dig_mem [CAPACITY];
  logic [VB-1:0]    b_val_mem [CAPACITY];
  logic [VB-1:0]    b_quo_mem [CAPACITY];

  logic [VB-1:0]    a_val_q, a_quo_q, b_val_q, b_quo_q;
  logic [DIG_W-1:0] a_dig_q;

  logic             a_we, b_we;
  logic [IDX_W-1:0] b_waddr;
  logic [VB-1:0]    b_wval, b_wquo;

  logic             div_start, div_busy, div_done;
  logic [VB-1:0]    div_quot;
  logic [DIG_W-1:0] div_digit;

  logic             in_xfer, slot_free, idx_end;

  ldrs_div_unit #(
    .RADIX(RADIX)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(b_quo_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .digit_o   (div_digit)
  );

  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign idx_end    = (idx_q == IDX_W'(cnt_q - CNT_W'(1)));
  assign div_start  = (state_q == S_EXT_GO);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    bkt_d       = bkt_q;
    ovf_d       = ovf_q;
    more_d      = more_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    a_we        = 1'b0;
    b_we        = 1'b0;
    b_waddr     = pos_q;
    b_wval      = a_val_q;
    b_wquo      = a_quo_q;
    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (cnt_q < CNT_W'(CAPACITY)) begin
            b_we    = 1'b1;
            b_waddr = IDX_W'(cnt_q);
            b_wval  = in_data_i.value;
            b_wquo  = in_data_i.value;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            state_d = S_EXT_RD;
            idx_d   = '0;
            more_d  = 1'b0;
          end
        end
      end
      S_EXT_RD: begin
        state_d = S_EXT_GO;
      end
      S_EXT_GO: begin
        state_d = S_EXT_WAIT;
      end
      S_EXT_WAIT: begin
        if (div_done) begin
          a_we = 1'b1;
          if (div_quot != '0) begin
            more_d = 1'b1;
          end
          if (idx_end) begin
            state_d = S_DST_RD;
            idx_d   = '0;
            bkt_d   = '0;
            pos_d   = '0;
          end else begin
            state_d = S_EXT_RD;
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end
      S_DST_RD: begin
        state_d = S_DST_CHK;
      end
      S_DST_CHK: begin
        if (a_dig_q == bkt_q) begin
          b_we  = 1'b1;
          pos_d = pos_q + IDX_W'(1);
        end
        state_d = S_DST_RD;
        if (idx_end) begin
          idx_d = '0;
          if (bkt_q == DIG_W'(RADIX - 1)) begin
            if (more_q) begin
              state_d = S_EXT_RD;
              more_d  = 1'b0;
            end else begin
              state_d = S_OUT_RD;
            end
          end else begin
            bkt_d = bkt_q + DIG_W'(1);
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_SEND;
      end
      S_OUT_SEND: begin
        if (slot_free) begin
          out_valid_d             = 1'b1;
          out_data_d.sorted_value = b_val_q;
          out_data_d.last_res     = idx_end;
          out_data_d.overflow     = ovf_q;
          if (idx_end) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            state_d = S_OUT_RD;
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      bkt_q       <= '0;
      ovf_q       <= 1'b0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      bkt_q       <= bkt_d;
      ovf_q       <= ovf_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_val_mem[idx_q] <= b_val_q;
      a_quo_mem[idx_q] <= div_quot;
      a_dig_mem[idx_q] <= div_digit;
    end
    a_val_q <= a_val_mem[idx_q];
    a_quo_q <= a_quo_mem[idx_q];
    a_dig_q <= a_dig_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_val_mem[b_waddr] <= b_wval;
      b_quo_mem[b_waddr] <= b_wquo;
    end
    b_val_q <= b_val_mem[idx_q];
    b_quo_q <= b_quo_mem[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("item count beyond capacity");

  a_out_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == S_OUT_SEND))
    else $error("result loaded outside output phase");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && $past(state_q == S_OUT_SEND)) |-> (cnt_q == '0 && !ovf_q))
    else $error("set state not cleared after last result");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the LSD decimal radix sorter: directed and random sets, sorted-order scoreboard.
module testbench;

  localparam int unsigned CAP           = ldrs_pkg::CAPACITY_DEF;
  localparam int unsigned BASE          = ldrs_pkg::RADIX_DEF;
  localparam longint unsigned VALUE_MAX = (64'd1 << ldrs_pkg::VALUE_BITS) - 1;
  localparam int unsigned QUIET_LIMIT   = 300000;

  typedef logic [ldrs_pkg::VALUE_BITS-1:0] value_t;

  class sorted_set_tracker;
    value_t              loaded [CAP];
    int unsigned         loaded_n;
    value_t              peak;
    bit                  dropped;
    ldrs_pkg::out_item_t pending_sorted [$];
    int unsigned         mismatches;

    function new();
      loaded_n   = 0;
      peak       = '0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    function void take_item(ldrs_pkg::in_item_t it);
      value_t              scratch [CAP];
      int unsigned         pass_cnt;
      int unsigned         pos;
      longint unsigned     div;
      longint unsigned     rest;
      ldrs_pkg::out_item_t r;
      if (loaded_n < CAP) begin
        loaded[loaded_n] = it.value;
        loaded_n++;
        if (it.value > peak) peak = it.value;
      end else begin
        dropped = 1'b1;
      end
      if (!it.last) return;
      pass_cnt = 1;
      rest = peak;
      while (rest >= BASE) begin
        rest = rest / BASE;
        pass_cnt++;
      end
      div = 1;
      for (int unsigned p = 0; p < pass_cnt; p++) begin
        pos = 0;
        for (int unsigned b = 0; b < BASE; b++) begin
          for (int unsigned i = 0; i < loaded_n; i++) begin
            if (((longint'(loaded[i]) / div) % BASE) == b) begin
              scratch[pos] = loaded[i];
              pos++;
            end
          end
        end
        for (int unsigned i = 0; i < pos; i++) loaded[i] = scratch[i];
        div = div * BASE;
      end
      for (int unsigned k = 0; k < loaded_n; k++) begin
        r.sorted_value = loaded[k];
        r.last_res     = (k + 1 == loaded_n);
        r.overflow     = dropped;
        pending_sorted = {pending_sorted, r};
      end
      loaded_n = 0;
      peak     = '0;
      dropped  = 1'b0;
    endfunction

    function void match_result(ldrs_pkg::out_item_t got);
      ldrs_pkg::out_item_t want;
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value=%0d last=%0b ovf=%0b",
                 $time, got.sorted_value, got.last_res, got.overflow);
        mismatches++;
        return;
      end
      want = pending_sorted.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                 $time, want.sorted_value, got.sorted_value);
        mismatches++;
      end
      if (got.last_res !== want.last_res) begin
        $display("%0t: last_res mismatch: expected %0b, actual %0b",
                 $time, want.last_res, got.last_res);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  ldrs_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  ldrs_pkg::out_item_t out_data_o;

  sorted_set_tracker tracker;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       items_sent;
  int unsigned       quiet_cycles = 0;

  lsd_decimal_radix_sort_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic value_t pick_value();
    logic [31:0]     raw;
    longint unsigned span;
    int unsigned     k;
    span = 1;
    case ($urandom_range(5))
      0: begin
        raw = $urandom;
        pick_value = raw[ldrs_pkg::VALUE_BITS-1:0];
      end
      1: pick_value = value_t'($urandom_range(BASE - 1));
      2: begin
        k = $urandom_range(1, 10);
        repeat (k) span = span * BASE;
        if (span > VALUE_MAX + 1) span = VALUE_MAX + 1;
        pick_value = value_t'($urandom_range(32'(span - 1)));
      end
      3: pick_value = value_t'(VALUE_MAX);
      4: begin
        k = $urandom_range(0, 9);
        repeat (k) span = span * BASE;
        pick_value = value_t'(span - $urandom_range(1));
      end
      default: pick_value = value_t'($urandom_range(99999));
    endcase
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) pick_size = $urandom_range(CAP + 1, CAP + 5);
    else if (r < 8) pick_size = $urandom_range(CAP / 2, CAP);
    else pick_size = $urandom_range(1, 8);
  endfunction

  task automatic send_item(input value_t v, input logic is_last);
    ldrs_pkg::in_item_t it;
    it.value = v;
    it.last  = is_last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_item(it);
    items_sent++;
  endtask

  task automatic send_list(input value_t vals [$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) tracker.match_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk_i);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned phase_goal;
    tracker        = new();
    send_idle_pct  = 11;
    recv_stall_pct = 46;
    items_sent     = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_list('{0});
    send_list('{value_t'(VALUE_MAX)});
    send_list('{5, 3, 9, 0, 1});
    send_list('{1000000000, 999999999, 10, 9, value_t'(VALUE_MAX), 0, 100});
    send_list('{7, 7, 3, 70, 7});
    send_list('{88, 44, 22, 11});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 46;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_goal = items_sent + 66;
      if (phase == 0) send_random_set(CAP);
      if (phase == 2) send_random_set(CAP + 2);
      while (items_sent < phase_goal) send_random_set(pick_size());
    end
    in_valid_i <= 1'b0;

    while (tracker.pending_sorted.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/ldrs_pkg.sv
rtl/ldrs_div_unit.sv
rtl/lsd_decimal_radix_sort_top.sv
dv/testbench.sv
